/* hdl/humidity_temperature_sample_convert_unit_defines.svh */
// Assertion macros for the humidity/temperature sample converter.
`ifndef HUMIDITY_TEMPERATURE_SAMPLE_CONVERT_UNIT_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_SAMPLE_CONVERT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HTSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/htsc_pkg.sv */
// Types, constants and CRC helper for the humidity/temperature sample converter.
package htsc_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t       CRC_POLY     = 8'h31;
  localparam byte_t       CRC_INIT     = 8'hFF;
  localparam logic [14:0] T_SPAN       = 15'd17500;
  localparam logic [14:0] T_OFFSET     = 15'd4500;
  localparam logic [6:0]  H_SPAN       = 7'd100;
  localparam logic [16:0] RAW_FULL     = 17'd65535;
  localparam logic [14:0] TEMP_INVALID = 15'h7FFF;
  localparam byte_t       HUM_INVALID  = 8'hFF;
  localparam byte_t       HUM_MAX      = 8'd100;

  localparam int TPROD_W = 31;
  localparam int HPROD_W = 23;

  typedef logic signed [14:0] temp_t;

  function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
    byte_t crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* hdl/htsc_ifs.sv */
// Input and result channel interfaces for the humidity/temperature sample converter.
interface htsc_in_if;
  logic            valid;
  logic            ready;
  htsc_pkg::byte_t temp_msb;
  htsc_pkg::byte_t temp_lsb;
  htsc_pkg::byte_t temp_check;
  htsc_pkg::byte_t hum_msb;
  htsc_pkg::byte_t hum_lsb;
  htsc_pkg::byte_t hum_check;

  modport source (output valid, temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb,
                  hum_check, input ready);
  modport sink (input valid, temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb,
                hum_check, output ready);
endinterface

interface htsc_out_if;
  logic            valid;
  logic            ready;
  logic            valid_res;
  htsc_pkg::temp_t temp_centi;
  htsc_pkg::byte_t hum_percent;

  modport source (output valid, valid_res, temp_centi, hum_percent, input ready);
  modport sink (input valid, valid_res, temp_centi, hum_percent, output ready);
endinterface

/* hdl/humidity_temperature_sample_convert_unit.sv */
// Top level: three-stage pipelined CRC check and raw-to-unit conversion of sensor readings.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------------
//   in_item   | sink      | temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb, hum_check
//   out_item  | source    | valid_res, temp_centi, hum_percent
//
// Each item is registered through stages 1, 2 and 3; one enters per cycle unless stalled.
// Stage 1 runs the first CRC byte and the scaling multiplies, stage 2 the second CRC
// byte and the remainder for division by 65535, stage 3 the correction and output.
// rst_n is synchronous and clears the stage valid bits only.
// A stalled output holds each stage that is full; empty stages still fill.
`include "humidity_temperature_sample_convert_unit_defines.svh"

module humidity_temperature_sample_convert_unit (
  input  logic       clk,
  input  logic       rst_n,
  htsc_in_if.sink    in_item,
  htsc_out_if.source out_item
);

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic en1, en2, en3;

  htsc_pkg::byte_t                   s1_tcrc_r, s1_tl_r, s1_tc_r;
  htsc_pkg::byte_t                   s1_hcrc_r, s1_hl_r, s1_hc_r;
  logic [htsc_pkg::TPROD_W-1:0]      s1_tprod_r;
  logic [htsc_pkg::HPROD_W-1:0]      s1_hprod_r;

  logic                              s2_ok_r;
  logic [14:0]                       s2_tq_r;
  logic [16:0]                       s2_tr_r;
  logic [6:0]                        s2_hq_r;
  logic [16:0]                       s2_hr_r;

  logic                              s3_ok_r;
  htsc_pkg::temp_t                   s3_temp_r;
  htsc_pkg::byte_t                   s3_hum_r;

  logic [14:0]                       tq_fix;
  logic [6:0]                        hq_fix;

  assign en3 = !v3_r || out_item.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_item.ready = en1;

  always_comb begin
    v1_nxt = en1 ? in_item.valid : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: first CRC byte, scale raw words
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_tcrc_r  <= htsc_pkg::crc8_byte(htsc_pkg::CRC_INIT, in_item.temp_msb);
      s1_tl_r    <= in_item.temp_lsb;
      s1_tc_r    <= in_item.temp_check;
      s1_hcrc_r  <= htsc_pkg::crc8_byte(htsc_pkg::CRC_INIT, in_item.hum_msb);
      s1_hl_r    <= in_item.hum_lsb;
      s1_hc_r    <= in_item.hum_check;
      s1_tprod_r <= htsc_pkg::TPROD_W'(htsc_pkg::T_SPAN)
                    * htsc_pkg::TPROD_W'({in_item.temp_msb, in_item.temp_lsb});
      s1_hprod_r <= htsc_pkg::HPROD_W'(htsc_pkg::H_SPAN)
                    * htsc_pkg::HPROD_W'({in_item.hum_msb, in_item.hum_lsb});
    end
  end

  // stage 2: finish CRC, estimate quotient and remainder of division by 65535
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ok_r <= (htsc_pkg::crc8_byte(s1_tcrc_r, s1_tl_r) == s1_tc_r)
                 && (htsc_pkg::crc8_byte(s1_hcrc_r, s1_hl_r) == s1_hc_r);
      s2_tq_r <= s1_tprod_r[htsc_pkg::TPROD_W-1:16];
      s2_tr_r <= {1'b0, s1_tprod_r[15:0]} + {2'b00, s1_tprod_r[htsc_pkg::TPROD_W-1:16]};
      s2_hq_r <= s1_hprod_r[htsc_pkg::HPROD_W-1:16];
      s2_hr_r <= {1'b0, s1_hprod_r[15:0]} + {10'b0, s1_hprod_r[htsc_pkg::HPROD_W-1:16]};
    end
  end

  // stage 3: correct quotient, offset temperature, substitute fill on CRC failure
  always_comb begin
    tq_fix = (s2_tr_r >= htsc_pkg::RAW_FULL) ? s2_tq_r + 15'd1 : s2_tq_r;
    hq_fix = (s2_hr_r >= htsc_pkg::RAW_FULL) ? s2_hq_r + 7'd1 : s2_hq_r;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ok_r <= s2_ok_r;
      if (s2_ok_r) begin
        s3_temp_r <= htsc_pkg::temp_t'(tq_fix - htsc_pkg::T_OFFSET);
        s3_hum_r  <= {1'b0, hq_fix};
      end else begin
        s3_temp_r <= htsc_pkg::temp_t'(htsc_pkg::TEMP_INVALID);
        s3_hum_r  <= htsc_pkg::HUM_INVALID;
      end
    end
  end

  assign out_item.valid       = v3_r;
  assign out_item.valid_res   = s3_ok_r;
  assign out_item.temp_centi  = s3_temp_r;
  assign out_item.hum_percent = s3_hum_r;

  `HTSC_ASSERT_NOW(a_fill_on_fail, clk, rst_n, out_item.valid && !out_item.valid_res, out_item.temp_centi == htsc_pkg::temp_t'(htsc_pkg::TEMP_INVALID) && out_item.hum_percent == htsc_pkg::HUM_INVALID, "CRC failure without fill pattern")
  `HTSC_ASSERT_NOW(a_range_on_pass, clk, rst_n, out_item.valid && out_item.valid_res, out_item.hum_percent <= htsc_pkg::HUM_MAX && out_item.temp_centi >= -htsc_pkg::temp_t'(htsc_pkg::T_OFFSET), "converted value out of range")
  `HTSC_ASSERT_NOW(a_full_only_on_stall, clk, rst_n, !in_item.ready, v1_r && v2_r && v3_r && !out_item.ready, "input blocked with pipeline not full")
  `HTSC_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_item.valid && in_item.ready, v1_r, "accepted item lost at stage 1")

endmodule
